/* hdl/stacc_pkg.sv */
// Shared constants and types for the shape tensor accumulator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package stacc_pkg;

    localparam int POS_W             = 16;
    localparam int SUM_W             = 52;
    localparam int CNT_W             = 21;
    localparam int LANES             = 6;
    localparam int QUEUE_DEPTH       = 2;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int MAX_PARTICLES_DEF = 1048576;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // lane order of the six moments
    localparam int L_XX = 0;
    localparam int L_XY = 1;
    localparam int L_XZ = 2;
    localparam int L_YY = 3;
    localparam int L_YZ = 4;
    localparam int L_ZZ = 5;

    typedef struct packed {
        logic reduced;
        logic last;
        logic origin;
    } item_flags_t;

endpackage

`default_nettype wire

/* hdl/shape_tensor_3d_accumulator_top.sv */
// Top level of the shape tensor accumulator: mode register, input side,
// queue and arithmetic sequencer. Depends on stacc_pkg and all stacc_* modules.
//
// Usage:
//   Input channel (in_valid / in_stall): one particle per transfer, pos_x/y/z
//   signed offsets, last_particle closes a set. Output channel (out_valid /
//   out_stall): one transfer per set with the six moment sums and the count.
//   Config channel (cfg_valid / cfg_ready, always ready): writes reduced_mode;
//   write it only while no particle is in flight.
//   In reduced mode each particle that is not at the origin passes through the
//   FRAC_BITS + 2 steps of the six-lane restoring divider. A two-entry queue
//   lets the input side keep taking particles while the sequencer works.
//   Reset clears the running sums and count, the mode and the result valid.
//   When the receiver stalls, the result holds; the next set's particles are
//   still summed, and the sequencer waits only when another result is ready.
`default_nettype none

module shape_tensor_3d_accumulator_top #(
    parameter int COORD_BITS    = stacc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS     = stacc_pkg::FRAC_BITS_DEF,
    parameter int MAX_PARTICLES = stacc_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic                                 reduced_mode,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [stacc_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [stacc_pkg::POS_W-1:0]   pos_y,
    input  wire logic signed [stacc_pkg::POS_W-1:0]   pos_z,
    input  wire logic                                 last_particle,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [stacc_pkg::SUM_W-1:0]        sum_xx,
    output logic signed [stacc_pkg::SUM_W-1:0]        sum_xy,
    output logic signed [stacc_pkg::SUM_W-1:0]        sum_xz,
    output logic signed [stacc_pkg::SUM_W-1:0]        sum_yy,
    output logic signed [stacc_pkg::SUM_W-1:0]        sum_yz,
    output logic signed [stacc_pkg::SUM_W-1:0]        sum_zz,
    output logic [stacc_pkg::CNT_W-1:0]               particle_total
);

    localparam int FLAG_W = $bits(stacc_pkg::item_flags_t);
    localparam int DATA_W = 3 * COORD_BITS + FLAG_W;

    logic                         mode_reg, mode_next;
    logic                         push_valid, push_ready;
    logic signed [COORD_BITS-1:0] push_x, push_y, push_z;
    stacc_pkg::item_flags_t       push_flags;
    logic                         pop_valid, pop_ready;
    logic [DATA_W-1:0]            pop_data;
    logic signed [COORD_BITS-1:0] pop_x, pop_y, pop_z;
    stacc_pkg::item_flags_t       pop_flags;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? reduced_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    stacc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .last_particle (last_particle),
        .mode          (mode_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_x        (push_x),
        .push_y        (push_y),
        .push_z        (push_z),
        .push_flags    (push_flags)
    );

    stacc_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_flags, push_x, push_y, push_z}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_flags = stacc_pkg::item_flags_t'(pop_data[DATA_W-1 -: FLAG_W]);
    assign pop_x     = pop_data[3*COORD_BITS-1 -: COORD_BITS];
    assign pop_y     = pop_data[2*COORD_BITS-1 -: COORD_BITS];
    assign pop_z     = pop_data[COORD_BITS-1:0];

    stacc_back #(
        .COORD_BITS    (COORD_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_x          (pop_x),
        .pop_y          (pop_y),
        .pop_z          (pop_z),
        .pop_flags      (pop_flags),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sum_xx         (sum_xx),
        .sum_xy         (sum_xy),
        .sum_xz         (sum_xz),
        .sum_yy         (sum_yy),
        .sum_yz         (sum_yz),
        .sum_zz         (sum_zz),
        .particle_total (particle_total)
    );

endmodule

`default_nettype wire

/* hdl/stacc_front.sv */
// Input side: takes a particle transfer, sizes the coordinates and tags it.
// Depends on stacc_pkg; feeds stacc_queue.
`default_nettype none

module stacc_front #(
    parameter int COORD_BITS = stacc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [stacc_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [stacc_pkg::POS_W-1:0]   pos_y,
    input  wire logic signed [stacc_pkg::POS_W-1:0]   pos_z,
    input  wire logic                                 last_particle,
    input  wire logic                                 mode,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output logic signed [COORD_BITS-1:0]              push_x,
    output logic signed [COORD_BITS-1:0]              push_y,
    output logic signed [COORD_BITS-1:0]              push_z,
    output stacc_pkg::item_flags_t                    push_flags
);

    assign push_x = COORD_BITS'(pos_x);
    assign push_y = COORD_BITS'(pos_y);
    assign push_z = COORD_BITS'(pos_z);

    assign push_flags.reduced = mode;
    assign push_flags.last    = last_particle;
    assign push_flags.origin  = (push_x == '0) && (push_y == '0) && (push_z == '0);

    assign push_valid = in_valid;
    assign in_stall   = !push_ready;

endmodule

`default_nettype wire

/* hdl/stacc_queue.sv */
// Two-entry queue between the input side and the arithmetic sequencer.
// Depends on stacc_pkg for its depth.
`default_nettype none

module stacc_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int DEPTH = stacc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_QW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/stacc_back.sv */
// Arithmetic sequencer: products, squared radius, six-lane restoring divide,
// saturating sums, particle count and the result register. Depends on stacc_pkg.
`default_nettype none

module stacc_back #(
    parameter int COORD_BITS    = stacc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS     = stacc_pkg::FRAC_BITS_DEF,
    parameter int MAX_PARTICLES = stacc_pkg::MAX_PARTICLES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  pop_valid,
    output logic                                       pop_ready,
    input  wire logic signed [COORD_BITS-1:0]          pop_x,
    input  wire logic signed [COORD_BITS-1:0]          pop_y,
    input  wire logic signed [COORD_BITS-1:0]          pop_z,
    input  wire stacc_pkg::item_flags_t                pop_flags,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [stacc_pkg::SUM_W-1:0]         sum_xx,
    output logic signed [stacc_pkg::SUM_W-1:0]         sum_xy,
    output logic signed [stacc_pkg::SUM_W-1:0]         sum_xz,
    output logic signed [stacc_pkg::SUM_W-1:0]         sum_yy,
    output logic signed [stacc_pkg::SUM_W-1:0]         sum_yz,
    output logic signed [stacc_pkg::SUM_W-1:0]         sum_zz,
    output logic [stacc_pkg::CNT_W-1:0]                particle_total
);

    localparam int SW        = stacc_pkg::SUM_W;
    localparam int CW        = stacc_pkg::CNT_W;
    localparam int NL        = stacc_pkg::LANES;
    localparam int PW        = 2 * COORD_BITS;
    localparam int QW        = FRAC_BITS + 2;
    localparam int DIV_STEPS = FRAC_BITS + 2;
    localparam int DC_W      = $clog2(DIV_STEPS);
    localparam longint CNT_FULL = (longint'(1) << CW) - 1;
    localparam logic [CW-1:0] CNT_CAP = (longint'(MAX_PARTICLES) > CNT_FULL) ?
                                        CW'(CNT_FULL) : CW'(MAX_PARTICLES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RSQ  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic signed [COORD_BITS-1:0] x_next, y_next, z_next;
    stacc_pkg::item_flags_t    flags_reg, flags_next;
    logic signed [PW-1:0]      prod_reg [NL];
    logic signed [PW-1:0]      prod_next [NL];
    logic [PW-1:0]             rsq_reg, rsq_next;
    logic [PW-1:0]             rem_reg [NL];
    logic [PW-1:0]             rem_next [NL];
    logic [QW-1:0]             quo_reg [NL];
    logic [QW-1:0]             quo_next [NL];
    logic                      neg_reg [NL];
    logic                      neg_next [NL];
    logic signed [SW:0]        term_reg [NL];
    logic signed [SW:0]        term_next [NL];
    logic [DC_W-1:0]           dcnt_reg, dcnt_next;
    logic signed [SW-1:0]      acc_reg [NL];
    logic signed [SW-1:0]      acc_next [NL];
    logic [CW-1:0]             seen_reg, seen_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SW-1:0]      res_reg [NL];
    logic signed [SW-1:0]      res_next [NL];
    logic [CW-1:0]             total_reg, total_next;

    logic [PW:0]               trial [NL];
    logic [PW:0]               diff [NL];
    logic                      fits [NL];
    logic [QW-1:0]             qstep [NL];
    logic [QW-1:0]             qround [NL];
    logic signed [SW:0]        ssum [NL];
    logic signed [SW-1:0]      sat [NL];
    logic [CW-1:0]             seen_inc;
    logic                      emit_ok;

    assign pop_ready      = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign sum_xx         = res_reg[stacc_pkg::L_XX];
    assign sum_xy         = res_reg[stacc_pkg::L_XY];
    assign sum_xz         = res_reg[stacc_pkg::L_XZ];
    assign sum_yy         = res_reg[stacc_pkg::L_YY];
    assign sum_yz         = res_reg[stacc_pkg::L_YZ];
    assign sum_zz         = res_reg[stacc_pkg::L_ZZ];
    assign particle_total = total_reg;

    assign emit_ok  = !out_valid_reg || !out_stall;
    assign seen_inc = (seen_reg < CNT_CAP) ? seen_reg + CW'(1) : seen_reg;

    // per-lane divide step and saturating add
    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            trial[k]  = (dcnt_reg == '0) ? {1'b0, rem_reg[k]} : {rem_reg[k], 1'b0};
            diff[k]   = trial[k] - {1'b0, rsq_reg};
            fits[k]   = (trial[k] >= {1'b0, rsq_reg});
            qstep[k]  = {quo_reg[k][QW-2:0], fits[k]};
            qround[k] = (qstep[k] + QW'(1)) >> 1;
            ssum[k]   = {acc_reg[k][SW-1], acc_reg[k]} + term_reg[k];
            if (ssum[k][SW] != ssum[k][SW-1])
            begin
                sat[k] = ssum[k][SW] ? stacc_pkg::SUM_MIN : stacc_pkg::SUM_MAX;
            end
            else
            begin
                sat[k] = ssum[k][SW-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        flags_next     = flags_reg;
        rsq_next       = rsq_reg;
        dcnt_next      = dcnt_reg;
        seen_next      = seen_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && out_stall;
        for (int k = 0; k < NL; k++)
        begin
            prod_next[k] = prod_reg[k];
            rem_next[k]  = rem_reg[k];
            quo_next[k]  = quo_reg[k];
            neg_next[k]  = neg_reg[k];
            term_next[k] = term_reg[k];
            acc_next[k]  = acc_reg[k];
            res_next[k]  = res_reg[k];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    x_next     = pop_x;
                    y_next     = pop_y;
                    z_next     = pop_z;
                    flags_next = pop_flags;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next[stacc_pkg::L_XX] = x_reg * x_reg;
                prod_next[stacc_pkg::L_XY] = x_reg * y_reg;
                prod_next[stacc_pkg::L_XZ] = x_reg * z_reg;
                prod_next[stacc_pkg::L_YY] = y_reg * y_reg;
                prod_next[stacc_pkg::L_YZ] = y_reg * z_reg;
                prod_next[stacc_pkg::L_ZZ] = z_reg * z_reg;
                state_next = ST_RSQ;
            end
            ST_RSQ:
            begin
                rsq_next = $unsigned(prod_reg[stacc_pkg::L_XX])
                         + $unsigned(prod_reg[stacc_pkg::L_YY])
                         + $unsigned(prod_reg[stacc_pkg::L_ZZ]);
                dcnt_next = '0;
                for (int k = 0; k < NL; k++)
                begin
                    neg_next[k] = prod_reg[k][PW-1];
                    rem_next[k] = prod_reg[k][PW-1] ? $unsigned(-prod_reg[k])
                                                    : $unsigned(prod_reg[k]);
                    quo_next[k] = '0;
                    if (flags_reg.reduced)
                    begin
                        term_next[k] = '0;
                    end
                    else
                    begin
                        term_next[k] = (SW+1)'(prod_reg[k]);
                    end
                end
                if (flags_reg.reduced && !flags_reg.origin)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_DIV:
            begin
                dcnt_next = dcnt_reg + DC_W'(1);
                for (int k = 0; k < NL; k++)
                begin
                    rem_next[k] = fits[k] ? diff[k][PW-1:0] : trial[k][PW-1:0];
                    quo_next[k] = qstep[k];
                    if (neg_reg[k])
                    begin
                        term_next[k] = -(SW+1)'($signed({1'b0, qround[k]}));
                    end
                    else
                    begin
                        term_next[k] = (SW+1)'($signed({1'b0, qround[k]}));
                    end
                end
                if (dcnt_reg == DC_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (!flags_reg.last)
                begin
                    for (int k = 0; k < NL; k++)
                    begin
                        acc_next[k] = sat[k];
                    end
                    seen_next  = seen_inc;
                    state_next = ST_IDLE;
                end
                else if (emit_ok)
                begin
                    for (int k = 0; k < NL; k++)
                    begin
                        res_next[k] = sat[k];
                        acc_next[k] = '0;
                    end
                    total_next     = seen_inc;
                    seen_next      = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NL; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < NL; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        flags_reg <= flags_next;
        rsq_reg   <= rsq_next;
        dcnt_reg  <= dcnt_next;
        total_reg <= total_next;
        for (int k = 0; k < NL; k++)
        begin
            prod_reg[k] <= prod_next[k];
            rem_reg[k]  <= rem_next[k];
            quo_reg[k]  <= quo_next[k];
            neg_reg[k]  <= neg_next[k];
            term_reg[k] <= term_next[k];
            res_reg[k]  <= res_next[k];
        end
    end

endmodule

`default_nettype wire
